/* rtl/core/smmc3_pkg.sv */
// Package for the scrambled bank mapper: request and result types,
// operation and register codes, address constants and bank-bit helpers.
// Depends on nothing.
package smmc3_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_REG_WRITE  = 2'd0,
    OP_CHR_LOOKUP = 2'd1,
    OP_PRG_LOOKUP = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_PRG_BANK_MAX = 1'b0,
    CFG_CHR_BANK_MAX = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  value;
  } req_t;

  typedef struct packed {
    logic [20:0] rom_offset;
    logic        offset_valid;
  } rsp_t;

  localparam logic [15:0] SCRAMBLE_ADDR    = 16'h5000;
  localparam logic [15:0] WRITE_ADDR_MASK  = 16'hE001;
  localparam logic [15:0] BANK_SELECT_ADDR = 16'h8000;
  localparam logic [15:0] BANK_DATA_ADDR   = 16'h8001;
  localparam logic [15:0] CHR_WINDOW_END   = 16'h2000;
  localparam logic [15:0] PRG_WINDOW_BASE  = 16'h8000;

  localparam logic [7:0]  PRG_SCRAMBLE_BASE = 8'h20;
  localparam logic [7:0]  CHR_PAIR_MASK     = 8'hFE;

  localparam logic [7:0]  PRG_BANK_MAX_RST = 8'd31;
  localparam logic [7:0]  CHR_BANK_MAX_RST = 8'd255;

  localparam logic [2:0]  PRG_REG_A = 3'd6;
  localparam logic [2:0]  PRG_REG_B = 3'd7;

  // Pattern bank-bit permutation
  function automatic logic [7:0] permute_chr(input logic [7:0] x);
    permute_chr = {x[5], x[4], x[2], x[6], x[7], x[3], x[1], x[0]};
  endfunction

  // Program bank-bit permutation; banks from 0x20 up are rebased first
  function automatic logic [7:0] permute_prg(input logic [7:0] x);
    logic [7:0] rebased;
    rebased = x - PRG_SCRAMBLE_BASE;
    if (x < PRG_SCRAMBLE_BASE) begin
      permute_prg = {3'b000, x[2], x[1], x[3], x[4], x[0]};
    end else begin
      permute_prg = permute_chr(rebased);
    end
  endfunction

  // Fold a bank number above the maximum back into range
  function automatic logic [7:0] bound_bank(input logic [7:0] b, input logic [7:0] max);
    bound_bank = (b > max) ? (b & max) : b;
  endfunction

endpackage

/* rtl/core/scrambled_mmc3_bank_mapper_top.sv */
// The result is registered and is valid in the cycle after acceptance.
// Throughput: one request per cycle while out_ready is high; the result
// register frees as it is taken. Register writes update mapper state at the
// accepting edge, so the next request already sees them.
// Reset (rst_n low, synchronous): all mapper state cleared, bank maximums
// return to 31 and 255, result register empty.
//
// Top level of the scrambled bank mapper; uses smmc3_pkg.
module scrambled_mmc3_bank_mapper_top
  import smmc3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  req_t     in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rsp_t     out_data,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] prg_bank_max_r;
  logic [7:0] chr_bank_max_r;
  logic       scramble_on_r;
  logic [2:0] sel_reg_r;
  logic       prg_swap_r;
  logic       chr_invert_r;
  logic [7:0] bank_r [8];

  logic       out_valid_r;
  rsp_t       out_data_r;
  rsp_t       rsp_nxt;
  logic       accept;

  logic [15:0] masked_addr;
  logic        is_write;

  logic [2:0] chr_slot;
  logic [2:0] chr_idx;
  logic [7:0] chr_raw;
  logic [7:0] chr_perm;
  logic [7:0] chr_pair;
  logic [7:0] chr_pair_odd;
  logic [7:0] chr_bank;

  logic [1:0] prg_slot;
  logic [7:0] prg_before_last;
  logic [7:0] prg_raw;
  logic [7:0] prg_perm;
  logic [7:0] prg_bank;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign masked_addr = in_data.address & WRITE_ADDR_MASK;
  assign is_write    = (in_data.operation == OP_REG_WRITE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_max_r <= PRG_BANK_MAX_RST;
      chr_bank_max_r <= CHR_BANK_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_BANK_MAX: prg_bank_max_r <= cfg_data;
        CFG_CHR_BANK_MAX: chr_bank_max_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Mapper state, updated by accepted register-write requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scramble_on_r <= 1'b0;
      sel_reg_r     <= 3'd0;
      prg_swap_r    <= 1'b0;
      chr_invert_r  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= 8'd0;
      end
    end else if (accept && is_write) begin
      priority if (in_data.address == SCRAMBLE_ADDR) begin
        scramble_on_r <= in_data.value[1];
      end else if (masked_addr == BANK_SELECT_ADDR) begin
        sel_reg_r    <= in_data.value[2:0];
        prg_swap_r   <= in_data.value[6];
        chr_invert_r <= in_data.value[7];
      end else if (masked_addr == BANK_DATA_ADDR) begin
        bank_r[sel_reg_r] <= in_data.value;
      end else begin
        // drop writes to unmapped addresses
      end
    end
  end

  // Pattern lookup: 2KB pairs low, 1KB banks high, swapped by chr_invert_r
  always_comb begin
    chr_slot = in_data.address[12:10] ^ {chr_invert_r, 2'b00};
    chr_idx  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    chr_raw  = bank_r[chr_idx];
    chr_perm = scramble_on_r ? permute_chr(chr_raw) : chr_raw;
    chr_pair = bound_bank(chr_perm, chr_bank_max_r) & CHR_PAIR_MASK;
    chr_pair_odd = bound_bank(chr_pair + 8'd1, chr_bank_max_r);
    if (chr_slot[2]) begin
      chr_bank = bound_bank(chr_perm, chr_bank_max_r);
    end else if (chr_slot[0]) begin
      chr_bank = chr_pair_odd;
    end else begin
      chr_bank = chr_pair;
    end
  end

  // Program lookup: fixed last bank, swappable second-last bank
  always_comb begin
    prg_slot        = in_data.address[14:13];
    prg_before_last = prg_bank_max_r - 8'd1;
    priority if (prg_slot == 2'd1) begin
      prg_raw = bank_r[PRG_REG_B];
    end else if (prg_slot == 2'd3) begin
      prg_raw = prg_bank_max_r;
    end else if ((prg_slot == 2'd0) == !prg_swap_r) begin
      prg_raw = bank_r[PRG_REG_A];
    end else begin
      prg_raw = prg_before_last;
    end
    prg_perm = scramble_on_r ? permute_prg(prg_raw) : prg_raw;
    prg_bank = bound_bank(prg_perm, prg_bank_max_r);
  end

  // Select the result for this request
  always_comb begin
    rsp_nxt = '0;
    unique case (op_t'(in_data.operation))
      OP_CHR_LOOKUP: begin
        if (in_data.address < CHR_WINDOW_END) begin
          rsp_nxt.rom_offset   = {3'b000, chr_bank, in_data.address[9:0]};
          rsp_nxt.offset_valid = 1'b1;
        end
      end
      OP_PRG_LOOKUP: begin
        if (in_data.address >= PRG_WINDOW_BASE) begin
          rsp_nxt.rom_offset   = {prg_bank, in_data.address[12:0]};
          rsp_nxt.offset_valid = 1'b1;
        end
      end
      OP_REG_WRITE, OP_NONE: rsp_nxt = '0;
      default:               rsp_nxt = '0;
    endcase
  end

  // Result register: load on accept, clear valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= rsp_nxt;
    end
  end

endmodule
